// ===== sv/qdgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdgcd_pkg: shared types and constants for the duration gcd unit
// Payload structs, sequencer states and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package qdgcd_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned UNIT_W    = 48;

  // duration * scale, then one carry bit for the rounding add
  localparam int unsigned PROD_W    = DUR_W + SCALE_W;
  localparam int unsigned SUM_W     = PROD_W + 1;

  // shared divider: dividend is gcd << FRAC_BITS
  localparam int unsigned DIVD_W    = TICK_W + FRAC_BITS;
  localparam int unsigned CNT_W     = $clog2(DIVD_W + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);
  // smallest unit: ceil(2^FRAC_BITS / 10000), i.e. 1e-4
  localparam int unsigned        MIN_UNIT_I  = ((1 << FRAC_BITS) + 9999) / 10000;
  localparam logic [DIVD_W-1:0]  MIN_UNIT    = DIVD_W'(MIN_UNIT_I);
  localparam logic [SUM_W-1:0]   ROUND_HALF  = SUM_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             start_sequence;
  } qdgcd_in_t;

  typedef struct packed {
    logic [TICK_W-1:0] gcd_ticks;
    logic              has_unit;
    logic [UNIT_W-1:0] unit_q16;
  } qdgcd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_EUC,
    ST_UNIT,
    ST_DIV,
    ST_DONE
  } qdgcd_state_e;

  typedef enum logic {
    DIV_MOD,
    DIV_UNIT
  } qdgcd_div_mode_e;

endpackage

`default_nettype wire

// ===== sv/quantized_duration_gcd_unit.sv =====
// Sequence: duration registered, product formed, rounded to ticks, then Euclid modulo steps
//   and one unit division on the shared restoring divider, then the output register loads;
//   a first value or a zero tick count skips the Euclid steps, and a zero count with no value held skips both.
// Throughput: one beat at a time; the next beat is taken only once the result has loaded
//   and the sequencer is back in idle.
// Reset: async, active low; clears gcd, seen flag, output valid, sequencer; scale 1000.
// ----------------------------------------------------------------------------
// quantized_duration_gcd_unit
// Rounds scaled Q16.16 durations to ticks, keeps their running gcd and derives the unit from it.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_duration_gcd_unit
  import qdgcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire qdgcd_in_t          in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      qdgcd_out_t         out_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [SCALE_W-1:0] cfg_data_i
);

  qdgcd_state_e    state_q, state_d;
  qdgcd_div_mode_e mode_q;

  logic [SCALE_W-1:0] scale_q;
  logic [SCALE_W-1:0] eff_scale;
  logic [DUR_W-1:0]   dur_q;
  logic [PROD_W-1:0]  prod_q;
  logic [TICK_W-1:0]  acc_q;
  logic               seen_q;
  logic [TICK_W-1:0]  gy_q;
  logic [UNIT_W-1:0]  unit_q;

  logic [TICK_W-1:0]  rem_q;
  logic [DIVD_W-1:0]  quo_q;
  logic [TICK_W-1:0]  den_q;
  logic [CNT_W-1:0]   cnt_q;

  logic               out_valid_q;
  qdgcd_out_t         out_data_q;

  logic               in_fire;
  logic               out_load;
  logic               div_last;

  logic [SUM_W-1:0]   round_sum;
  logic [SUM_W-1:0]   ticks_full;
  logic [TICK_W-1:0]  ticks;

  logic [TICK_W:0]    div_shift;
  logic [TICK_W:0]    div_diff;
  logic               div_ge;
  logic [TICK_W-1:0]  rem_d;
  logic [DIVD_W-1:0]  quo_d;
  logic [DIVD_W-1:0]  unit_clamped;

  assign cfg_ready_o = 1'b1;
  assign eff_scale   = (scale_q == '0) ? SCALE_W'(1) : scale_q;

  // round half up, then saturate to 32 bits
  assign round_sum  = {1'b0, prod_q} + ROUND_HALF;
  assign ticks_full = round_sum >> FRAC_BITS;
  assign ticks      = (ticks_full[SUM_W-1:TICK_W] != '0) ? '1 : ticks_full[TICK_W-1:0];

  // one restoring division step
  assign div_shift = {rem_q, quo_q[DIVD_W-1]};
  assign div_diff  = div_shift - {1'b0, den_q};
  assign div_ge    = ~div_diff[TICK_W];
  assign rem_d     = div_ge ? div_diff[TICK_W-1:0] : div_shift[TICK_W-1:0];
  assign quo_d     = {quo_q[DIVD_W-2:0], div_ge};
  assign div_last  = (cnt_q == CNT_W'(1));

  assign unit_clamped = (quo_d < MIN_UNIT) ? MIN_UNIT : quo_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_RND;
      ST_RND: begin
        if (ticks == '0) begin
          state_d = seen_q ? ST_UNIT : ST_DONE;
        end else begin
          state_d = seen_q ? ST_EUC : ST_UNIT;
        end
      end
      ST_EUC: begin
        state_d = (gy_q == '0) ? ST_UNIT : ST_DIV;
      end
      ST_UNIT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) state_d = (mode_q == DIV_MOD) ? ST_EUC : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: out_load   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= SCALE_RESET;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mode_q      <= DIV_MOD;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) scale_q <= cfg_data_i;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire && in_data_i.start_sequence) begin
            acc_q  <= '0;
            seen_q <= 1'b0;
          end
        end
        ST_RND: begin
          if (ticks != '0 && !seen_q) begin
            acc_q  <= ticks;
            seen_q <= 1'b1;
          end
        end
        ST_EUC: begin
          if (gy_q != '0) begin
            cnt_q  <= CNT_W'(TICK_W);
            mode_q <= DIV_MOD;
          end
        end
        ST_UNIT: begin
          cnt_q  <= CNT_W'(DIVD_W);
          mode_q <= DIV_UNIT;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          // advance Euclid: x <- y, y <- x mod y
          if (div_last && mode_q == DIV_MOD) acc_q <= gy_q;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) dur_q <= in_data_i.duration;
      end
      ST_MUL: prod_q <= PROD_W'(dur_q) * PROD_W'(eff_scale);
      ST_RND: gy_q <= ticks;
      ST_EUC: begin
        rem_q <= '0;
        quo_q <= {acc_q, {FRAC_BITS{1'b0}}};
        den_q <= gy_q;
      end
      ST_UNIT: begin
        rem_q <= '0;
        quo_q <= {acc_q, {FRAC_BITS{1'b0}}};
        den_q <= TICK_W'(eff_scale);
      end
      ST_DIV: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        if (div_last) begin
          if (mode_q == DIV_MOD) begin
            gy_q <= rem_d;
          end else begin
            unit_q <= unit_clamped[UNIT_W-1:0];
          end
        end
      end
      default: begin
        dur_q <= dur_q;
      end
    endcase

    if (out_load) begin
      out_data_q.gcd_ticks <= seen_q ? acc_q : '0;
      out_data_q.has_unit  <= seen_q;
      out_data_q.unit_q16  <= seen_q ? unit_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_unit |->
      out_data_o.gcd_ticks == '0 && out_data_o.unit_q16 == '0)
    else $error("result without unit carries nonzero fields");

  a_unit_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_unit |->
      out_data_o.unit_q16 >= UNIT_W'(MIN_UNIT_I) && out_data_o.gcd_ticks != '0)
    else $error("reported unit below minimum or gcd zero");

  a_seen_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q && state_q != ST_IDLE |-> acc_q != '0)
    else $error("gcd accumulator zero while a value was seen");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q != '0 && den_q != '0)
    else $error("divider running with zero count or zero divisor");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> state_q == ST_IDLE && out_valid_q)
    else $error("result load did not return the sequencer to idle");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quantized_duration_gcd_unit
// Sends Q16.16 note durations over the input channel and compares every
// result beat with the directed table's expected values or an in-bench predictor
// of the tick rounding, running gcd and unit division. A directed table comes
// first, then random musical phrases and noise under several sender idle and
// receiver stall mixes, with scale rewrites between phrases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import qdgcd_pkg::*;
();

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DUR_W-1:0]   duration;
    logic               start_sequence;
    logic               typed;
    logic [TICK_W-1:0]  gcd_ticks;
    logic               has_unit;
    logic [UNIT_W-1:0]  unit_q16;
  } note_row_t;

  localparam int NUM_ROWS     = 23;
  localparam int PHASE_NOTES  = 350;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE_LIMIT = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  qdgcd_in_t          in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  qdgcd_out_t         out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [SCALE_W-1:0] cfg_data_i;

  // predictor state
  logic [SCALE_W-1:0] model_scale = SCALE_RESET;
  logic [TICK_W-1:0]  run_gcd     = '0;
  logic               run_seen    = 1'b0;

  qdgcd_out_t pending_gcd_q[$];
  qdgcd_out_t want_gcd;
  note_row_t  dir_rows [NUM_ROWS];

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int notes_sent  = 0;
  int results_ok  = 0;
  int mismatches  = 0;
  int phrases     = 0;
  int scale_wrs   = 0;

  quantized_duration_gcd_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #100_000_000;
    $display("FAIL quantized_duration_gcd_unit");
    $finish;
  end

  // Round to ticks, fold into the running gcd and derive the unit.
  function automatic qdgcd_out_t predict_tick_gcd(input qdgcd_in_t beat);
    logic [63:0]        prod;
    logic [63:0]        ticks64;
    logic [63:0]        unit;
    logic [TICK_W-1:0]  ticks;
    logic [TICK_W-1:0]  a;
    logic [TICK_W-1:0]  b;
    logic [TICK_W-1:0]  r;
    logic [SCALE_W-1:0] eff;
    qdgcd_out_t         res;
    eff = (model_scale == '0) ? SCALE_W'(1) : model_scale;
    if (beat.start_sequence) begin
      run_gcd  = '0;
      run_seen = 1'b0;
    end
    prod    = 64'(beat.duration) * 64'(eff);
    ticks64 = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    ticks   = (ticks64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ticks64[TICK_W-1:0];
    if (ticks != '0) begin
      if (!run_seen) begin
        run_gcd = ticks;
      end else begin
        a = run_gcd;
        b = ticks;
        while (b != '0) begin
          r = a % b;
          a = b;
          b = r;
        end
        run_gcd = a;
      end
      run_seen = 1'b1;
    end
    res = '0;
    if (run_seen) begin
      unit = (64'(run_gcd) << FRAC_BITS) / 64'(eff);
      if (unit < 64'(MIN_UNIT_I)) unit = 64'(MIN_UNIT_I);
      res.gcd_ticks = run_gcd;
      res.has_unit  = 1'b1;
      res.unit_q16  = unit[UNIT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(6))
      0:       return SCALE_W'(1);
      1:       return SCALE_W'(65535);
      2:       return '0;
      3:       return SCALE_W'(960);
      4:       return SCALE_W'(1000);
      default: return SCALE_W'($urandom_range(65535));
    endcase
  endfunction

  // Note value grid of a phrase: straight, triplet, long or odd fractions.
  function automatic logic [DUR_W-1:0] pick_base();
    case ($urandom_range(4))
      0:       return DUR_W'(32'h10000 >> $urandom_range(6));
      1:       return DUR_W'((32'h10000 >> $urandom_range(4)) / 3);
      2:       return DUR_W'(32'h10000 * $urandom_range(1, 4));
      3:       return DUR_W'(32'h10000 / $urandom_range(1, 12));
      default: return DUR_W'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic offer_note(input qdgcd_in_t beat, input logic typed,
                            input qdgcd_out_t typed_res);
    int         gap;
    qdgcd_out_t res;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_tick_gcd(beat);
    pending_gcd_q = {pending_gcd_q, (typed ? typed_res : res)};
    notes_sent++;
  endtask

  task automatic send_note(input logic [DUR_W-1:0] dur, input logic start);
    qdgcd_in_t beat;
    beat.duration       = dur;
    beat.start_sequence = start;
    offer_note(beat, 1'b0, '0);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_gcd_q.size() != 0);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    drain_pending();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_scale = value;
    scale_wrs++;
  endtask

  // A phrase: start flag on the first note, then multiples of one grid value,
  // with the odd dotted note and rest.
  task automatic play_phrase();
    logic [DUR_W-1:0] base;
    logic [DUR_W-1:0] dur;
    int               len;
    base = pick_base();
    len  = $urandom_range(3, 12);
    for (int i = 0; i < len; i++) begin
      dur = base * DUR_W'($urandom_range(1, 8));
      if ($urandom_range(9) == 0) dur = dur + (dur >> 1);
      if ($urandom_range(19) == 0) dur = '0;
      send_note(dur, i == 0);
    end
    phrases++;
  endtask

  task automatic play_noise();
    logic [DUR_W-1:0] dur;
    int               cnt;
    cnt = $urandom_range(1, 4);
    repeat (cnt) begin
      case ($urandom_range(3))
        0:       dur = DUR_W'($urandom);
        1:       dur = DUR_W'($urandom_range(65535));
        2:       dur = '0;
        default: dur = DUR_W'($urandom) >> $urandom_range(31);
      endcase
      send_note(dur, 1'(($urandom_range(3) == 0)));
    end
  endtask

  // Receiver side: stall at random or hold off on request; check each beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_gcd_q.size() == 0) begin
          $display("%0t: unexpected result beat gcd=%h has=%b unit=%h", $time,
                   out_data_o.gcd_ticks, out_data_o.has_unit, out_data_o.unit_q16);
          mismatches++;
        end else begin
          want_gcd = pending_gcd_q.pop_front();
          if (out_data_o.gcd_ticks !== want_gcd.gcd_ticks ||
              out_data_o.has_unit  !== want_gcd.has_unit  ||
              out_data_o.unit_q16  !== want_gcd.unit_q16) begin
            $display("%0t: mismatch expected gcd=%h has=%b unit=%h, got gcd=%h has=%b unit=%h",
                     $time, want_gcd.gcd_ticks, want_gcd.has_unit, want_gcd.unit_q16,
                     out_data_o.gcd_ticks, out_data_o.has_unit, out_data_o.unit_q16);
            mismatches++;
          end else begin
            results_ok++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int         phase_start;
    logic       pressure_done;
    note_row_t  row;
    qdgcd_in_t  beat;
    qdgcd_out_t typed_res;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    pressure_done = 1'b0;

    // scale, duration, start, typed, gcd, has_unit, unit
    dir_rows = '{
      '{16'd1000,  32'h0000_0000, 1'b0, 1'b1, 32'd0,       1'b0, 48'd0},
      '{16'd1000,  32'h0000_0001, 1'b0, 1'b1, 32'd0,       1'b0, 48'd0},
      '{16'd1000,  32'h0001_0000, 1'b0, 1'b1, 32'd1000,    1'b1, 48'h1_0000},
      '{16'd1000,  32'h0000_8000, 1'b0, 1'b1, 32'd500,     1'b1, 48'h8000},
      '{16'd1000,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd1000,  32'h0000_0000, 1'b1, 1'b1, 32'd0,       1'b0, 48'd0},
      '{16'd1000,  32'h0001_8000, 1'b1, 1'b1, 32'd1500,    1'b1, 48'h1_8000},
      '{16'd1000,  32'h0001_0000, 1'b0, 1'b1, 32'd500,     1'b1, 48'h8000},
      '{16'd1000,  32'h0000_5555, 1'b0, 1'b1, 32'd1,       1'b1, 48'd65},
      '{16'd65535, 32'h0000_0001, 1'b1, 1'b1, 32'd1,       1'b1, 48'd7},
      '{16'd65535, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd1,       1'b1, 48'd7},
      '{16'd65535, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd65535, 32'h1234_5678, 1'b0, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd0,     32'h0001_0000, 1'b1, 1'b1, 32'd1,       1'b1, 48'h1_0000},
      '{16'd0,     32'h0000_8000, 1'b0, 1'b1, 32'd1,       1'b1, 48'h1_0000},
      '{16'd0,     32'h0000_7FFF, 1'b0, 1'b1, 32'd1,       1'b1, 48'h1_0000},
      '{16'd0,     32'h0000_7FFF, 1'b1, 1'b1, 32'd0,       1'b0, 48'd0},
      '{16'd0,     32'hFFFF_FFFF, 1'b0, 1'b1, 32'h1_0000,  1'b1, 48'h1_0000_0000},
      '{16'd1,     32'hAAAA_AAAA, 1'b1, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd1,     32'h5555_5555, 1'b0, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd40000, 32'h0003_0000, 1'b1, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd40000, 32'h0005_0000, 1'b0, 1'b0, 32'd0,       1'b0, 48'd0},
      '{16'd1000,  32'h0001_0000, 1'b1, 1'b1, 32'd1000,    1'b1, 48'h1_0000}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.scale != model_scale) write_scale(row.scale);
      beat.duration       = row.duration;
      beat.start_sequence = row.start_sequence;
      typed_res.gcd_ticks = row.gcd_ticks;
      typed_res.has_unit  = row.has_unit;
      typed_res.unit_q16  = row.unit_q16;
      offer_note(beat, row.typed, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 73; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      write_scale(pick_scale());
      phase_start = notes_sent;
      while (notes_sent - phase_start < PHASE_NOTES) begin
        // hold the receiver off while notes keep coming, so the input stalls
        if (ph == 0 && !pressure_done && notes_sent - phase_start > 100) begin
          hold_left = HOLD_CYCLES;
          for (int k = 0; k < 6; k++) send_note(DUR_W'(32'h4000 * (k + 1)), k == 0);
          pressure_done = 1'b1;
        end
        if ($urandom_range(99) < 80) play_phrase();
        else play_noise();
        if ($urandom_range(14) == 0) drain_pending();
        if ($urandom_range(29) == 0) write_scale(pick_scale());
      end
    end

    drain_pending();
    stall_pct = 0;
    repeat (SETTLE_LIMIT) @(posedge clk_i);

    $display("Sent %0d notes (%0d phrases) across %0d scale settings, %0d results matched",
             notes_sent, phrases, scale_wrs, results_ok);
    $display("Idle mixes: none, sender idle, receiver stall, both; one long receiver hold");
    if (mismatches == 0 && pending_gcd_q.size() == 0) begin
      $display("PASS quantized_duration_gcd_unit");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches,
               pending_gcd_q.size());
      $display("FAIL quantized_duration_gcd_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
